// File: rtl/sliding_window_statistics_unit_macros.svh
// Assertion macros for the sliding window statistics unit.
// Define ASSERT_OFF to compile the checks out.
`ifndef SLIDING_WINDOW_STATISTICS_UNIT_MACROS_SVH
`define SLIDING_WINDOW_STATISTICS_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SWS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SWS_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SWS_ASSERT(label, clk, rst_n, prop, msg)
`define SWS_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: rtl/sws_pkg.sv
// Shared constants for the sliding window statistics unit.
// No dependencies.
package sws_pkg;
    localparam int unsigned WindowDepth = 64;
    localparam int unsigned CfgWidth    = 7;
    localparam int unsigned DataWidth   = 64;
    localparam int unsigned CountWidth  = 31;
    localparam logic [30:0] CountLimit  = 31'h7FFF_FFFF;
    localparam logic        FuncPush    = 1'b0;
    localparam logic        FuncRestart = 1'b1;
endpackage

// File: rtl/sliding_window_statistics_unit.sv
// Sliding window statistics unit: running min, max, sum and mean.
// Depends on sws_pkg and sliding_window_statistics_unit_macros.svh.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_func, i_sample
//  result  | out       | o_valid / i_stall  | o_minimum, o_maximum, o_total, o_mean
//  config  | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (window_size)
//
// A push holds the input from its accepting edge to the next one: read, sum,
// 64 serial divide steps, update, output and idle. A rescan is run when an
// extreme leaves the window. A restart item goes straight to output. History
// is one single-port memory, read one entry a cycle during the rescan. Reset
// is synchronous, active low. The result register holds while i_stall is
// high; o_stall stays high until it is taken.
`include "sliding_window_statistics_unit_macros.svh"
module sliding_window_statistics_unit #(
    parameter int unsigned WINDOW_DEPTH = sws_pkg::WindowDepth
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_func,
    input  logic signed [sws_pkg::DataWidth-1:0] i_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [sws_pkg::DataWidth-1:0] o_minimum,
    output logic signed [sws_pkg::DataWidth-1:0] o_maximum,
    output logic signed [sws_pkg::DataWidth-1:0] o_total,
    output logic signed [sws_pkg::DataWidth-1:0] o_mean,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sws_pkg::CfgWidth-1:0]      i_cfg_data
);
    localparam int unsigned Dw = sws_pkg::DataWidth;
    localparam int unsigned Cw = sws_pkg::CountWidth;
    localparam int unsigned Aw = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned Sw = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned Kw = $clog2(Dw + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_LEAVE, S_DIV, S_SCAN, S_DONE, S_OUT
    } t_state;

    t_state               r_state;
    logic [sws_pkg::CfgWidth-1:0] r_win;
    logic [Aw-1:0]        r_head;
    logic [Cw-1:0]        r_count;
    logic [Dw-1:0]        r_min, r_max, r_sum, r_mean, r_last, r_x, r_leave;
    logic                 r_first, r_slide, r_scan_min, r_scan_max, r_neg;
    logic [Dw-1:0]        r_quo, r_rem, r_dvd;
    logic [Cw-1:0]        r_dvs;
    logic [Kw-1:0]        r_k;
    logic [Sw-1:0]        r_i, r_size;
    logic [Dw-1:0]        r_rd;
    logic                 r_rd_ok;
    logic [Aw-1:0]        r_rd_idx;
    logic                 r_outv;
    logic [Dw-1:0]        mem [WINDOW_DEPTH];

    logic [Sw-1:0]        size_c;
    logic [Dw:0]          rem_sh;
    logic [Dw:0]          rem_sub;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_outv;

    always_comb begin
        if ({{(32-sws_pkg::CfgWidth){1'b0}}, r_win} > WINDOW_DEPTH) begin
            size_c = Sw'(WINDOW_DEPTH);
        end else begin
            size_c = Sw'(r_win);
        end
        rem_sh  = {r_rem, r_dvd[Dw-1]};
        rem_sub = rem_sh - {{(Dw+1-Cw){1'b0}}, r_dvs};
    end

    // History memory: one port, read every cycle and written in the done state.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && r_size != '0) begin
            mem[r_head] <= r_x;
        end
        r_rd <= mem[(r_state == S_SCAN) ? Aw'(r_i) : r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_win    <= '0;
            r_head   <= '0;
            r_count  <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_sum    <= '0;
            r_mean   <= '0;
            r_last   <= '0;
            r_size   <= '0;
            r_first  <= 1'b1;
            r_outv   <= 1'b0;
            r_rd_ok  <= 1'b0;
        end else begin
            r_rd_ok  <= (r_state == S_SCAN) && (r_i != r_size);
            r_rd_idx <= Aw'(r_i);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_win <= i_cfg_data;
                    end
                    if (i_valid) begin
                        if (i_func == sws_pkg::FuncRestart) begin
                            r_min   <= r_last;
                            r_max   <= r_last;
                            r_sum   <= '0;
                            r_head  <= '0;
                            r_count <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_x    <= i_sample;
                            r_last <= i_sample;
                            r_size <= size_c;
                            if (r_first) begin
                                r_first <= 1'b0;
                                r_min   <= i_sample;
                                r_max   <= i_sample;
                                r_sum   <= '0;
                                r_head  <= '0;
                                r_count <= '0;
                            end else if (size_c != '0 && Sw'(r_head) >= size_c) begin
                                r_head <= '0;
                            end
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // memory read of the leaving entry is in flight
                    r_slide <= (r_size != '0) &&
                               (r_count >= Cw'(r_size));
                    r_state <= S_LEAVE;
                end
                S_LEAVE: begin
                    logic [Dw-1:0] s;
                    s = r_sum + r_x - (r_slide ? r_rd : '0);
                    r_leave <= r_rd;
                    r_sum   <= s;
                    r_neg   <= s[Dw-1];
                    r_dvd   <= s[Dw-1] ? (~s + 1'b1) : s;
                    r_dvs   <= r_slide ? r_count : (r_count + 1'b1);
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_k     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (!rem_sub[Dw]) begin
                        r_rem <= rem_sub[Dw-1:0];
                        r_quo <= {r_quo[Dw-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[Dw-1:0];
                        r_quo <= {r_quo[Dw-2:0], 1'b0};
                    end
                    r_dvd <= {r_dvd[Dw-2:0], 1'b0};
                    r_k   <= r_k + 1'b1;
                    if (r_k == Kw'(Dw - 1)) begin
                        r_scan_min <= r_slide && (r_min == r_leave);
                        r_scan_max <= r_slide && (r_max == r_leave);
                        if (!(r_slide && r_min == r_leave) &&
                            $signed(r_x) < $signed(r_min)) begin
                            r_min <= r_x;
                        end
                        if (!(r_slide && r_max == r_leave) &&
                            $signed(r_x) > $signed(r_max)) begin
                            r_max <= r_x;
                        end
                        if (r_slide && r_min == r_leave) r_min <= r_x;
                        if (r_slide && r_max == r_leave) r_max <= r_x;
                        r_i     <= '0;
                        r_state <= (r_slide && (r_min == r_leave || r_max == r_leave))
                                   ? S_SCAN : S_DONE;
                    end
                end
                S_SCAN: begin
                    // one entry read per cycle; compare the one from last cycle
                    if (r_rd_ok && r_rd_idx != r_head) begin
                        if (r_scan_min && $signed(r_rd) < $signed(r_min)) r_min <= r_rd;
                        if (r_scan_max && $signed(r_rd) > $signed(r_max)) r_max <= r_rd;
                    end
                    if (r_i == r_size) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                    end
                end
                S_DONE: begin
                    logic [Cw-1:0] c;
                    r_mean <= r_neg ? (~r_quo + 1'b1) : r_quo;
                    c = r_slide ? r_count : (r_count + 1'b1);
                    if (c >= sws_pkg::CountLimit) begin
                        r_min   <= r_last;
                        r_max   <= r_last;
                        r_sum   <= '0;
                        r_head  <= '0;
                        r_count <= '0;
                    end else begin
                        r_count <= c;
                        if (r_size != '0) begin
                            if (Sw'(r_head) + 1'b1 >= r_size) r_head <= '0;
                            else r_head <= r_head + 1'b1;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_outv) begin
                        r_outv <= 1'b1;
                    end else if (!i_stall) begin
                        r_outv  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_minimum = r_min;
    assign o_maximum = r_max;
    assign o_total   = r_sum;
    assign o_mean    = r_mean;

    `SWS_ASSERT(a_out_only_in_out, i_clk, i_rst_n, r_outv |-> r_state == S_OUT, "result outside output state")
    `SWS_ASSERT(a_no_cfg_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> !o_cfg_ready, "config open while busy")
    `SWS_ASSERT(a_head_in_win, i_clk, i_rst_n, (r_state == S_OUT && r_size != '0) |-> Sw'(r_head) < r_size, "head beyond window")
    `SWS_ASSERT(a_div_done, i_clk, i_rst_n, (r_state == S_DIV) |-> r_dvs != '0, "zero divisor")
endmodule

// File: tb/sliding_window_statistics_unit_tb.sv
// Self-checking testbench for the sliding window statistics unit.
// Depends on sws_pkg and the sliding_window_statistics_unit RTL; drives random
// stall/valid gaps and compares each result item with an internal predictor.
module sliding_window_statistics_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [sws_pkg::DataWidth-1:0] t_word;
    typedef struct packed {
        t_word minimum;
        t_word maximum;
        t_word total;
        t_word mean;
    } t_stats;
    typedef struct {
        logic   func;
        t_word  sample;
        logic   has_exp;
        t_stats exp;
    } t_stim_row;

    localparam int unsigned CycleLimit = 4_000_000;
    localparam int unsigned RandomItems = 1300;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    logic i_func;
    t_word i_sample;
    logic o_valid;
    logic i_stall;
    t_word o_minimum, o_maximum, o_total, o_mean;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [sws_pkg::CfgWidth-1:0] i_cfg_data;

    sliding_window_statistics_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_sample(i_sample),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_minimum(o_minimum), .o_maximum(o_maximum),
        .o_total(o_total), .o_mean(o_mean),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [sws_pkg::CfgWidth-1:0] win_size;
    t_word ring [sws_pkg::WindowDepth];
    int unsigned head;
    int unsigned count;
    t_word lo, hi, sum, avg, last;
    logic first_push;

    t_stats expected_stats[$];
    int unsigned mismatches = 0;
    int unsigned table_errors = 0;
    int unsigned cycles = 0;
    bit hold_off = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("sliding_window_statistics_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic void clear_stats();
        lo = last;
        hi = last;
        sum = '0;
        head = 0;
        count = 0;
    endfunction

    function automatic t_stats predict_stats(logic func, t_word x);
        int unsigned size;
        bit slide;
        t_word gone;
        t_word m;
        longint signed div;
        t_stats r;
        size = (win_size > sws_pkg::WindowDepth) ? sws_pkg::WindowDepth : win_size;
        gone = '0;
        if (func == sws_pkg::FuncRestart) begin
            clear_stats();
        end else begin
            last = x;
            if (first_push) begin
                clear_stats();
                first_push = 1'b0;
            end
            if (size > 0 && head >= size) head = 0;
            slide = size > 0 && count >= size;
            if (slide) gone = ring[head];
            sum = sum + x;
            if (slide) sum = sum - gone;
            div = slide ? count : count + 1;
            avg = sum / div;
            if (slide) begin
                if (lo == gone) begin
                    m = x;
                    for (int unsigned i = 0; i < size; i++)
                        if (i != head && ring[i] < m) m = ring[i];
                    lo = m;
                end else if (x < lo) lo = x;
                if (hi == gone) begin
                    m = x;
                    for (int unsigned i = 0; i < size; i++)
                        if (i != head && ring[i] > m) m = ring[i];
                    hi = m;
                end else if (x > hi) hi = x;
            end else begin
                if (x < lo) lo = x;
                if (x > hi) hi = x;
            end
            if (size > 0) begin
                ring[head] = x;
                head++;
                if (head >= size) head = 0;
            end
            if (size == 0 || count < size) count++;
            if (count >= sws_pkg::CountLimit) clear_stats();
        end
        r.minimum = lo;
        r.maximum = hi;
        r.total = sum;
        r.mean = avg;
        return r;
    endfunction

    // result side: random stall, long hold-off on request
    initial begin
        int unsigned gap;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (gap != 0 || hold_off) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk iff o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item");
            end else begin
                e = expected_stats.pop_front();
                if (e.minimum !== o_minimum || e.maximum !== o_maximum ||
                    e.total !== o_total || e.mean !== o_mean) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp min %0d max %0d sum %0d mean %0d,",
                                  " got %0d %0d %0d %0d"},
                            e.minimum, e.maximum, e.total, e.mean,
                            o_minimum, o_maximum, o_total, o_mean);
                end
            end
        end
    end

    // hold the item until accepted; leave valid high so a zero gap follows directly
    task automatic offer_item(logic func, t_word x, int unsigned max_gap);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= func;
        i_sample <= x;
        @(posedge i_clk iff !o_stall);
    endtask

    task automatic send_item(logic func, t_word x, int unsigned max_gap);
        expected_stats.push_back(predict_stats(func, x));
        offer_item(func, x, max_gap);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_window(logic [sws_pkg::CfgWidth-1:0] w);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
        win_size = w;
    endtask

    function automatic t_word rand_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {63{1'b1}}};
            1: return {1'b1, 63'd0};
            2: return t_word'($urandom_range(0, 20)) - 10;
            3: return t_word'($urandom_range(0, 6));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    t_stim_row directed [$];
    localparam t_word Wmax = {1'b0, {63{1'b1}}};
    localparam t_word Wmin = {1'b1, 63'd0};

    initial begin
        t_stats got;
        // window settings; a restart opens each phase, so history is rewritten
        // from head 0 before any entry is read
        logic [sws_pkg::CfgWidth-1:0] phases [6];
        int unsigned per_phase;
        phases = '{7'd0, 7'd1, 7'd4, 7'd64, 7'd127, 7'd9};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = sws_pkg::FuncPush;
        i_sample = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        win_size = '0;
        head = 0; count = 0;
        lo = '0; hi = '0; sum = '0; avg = '0; last = '0;
        first_push = 1'b1;
        foreach (ring[i]) ring[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // restart straight after reset returns zeros
        directed.push_back('{sws_pkg::FuncRestart, 64'sd5, 1'b1, '{'0, '0, '0, '0}});
        directed.push_back('{sws_pkg::FuncPush, Wmax, 1'b1, '{Wmax, Wmax, Wmax, Wmax}});
        directed.push_back('{sws_pkg::FuncPush, Wmax, 1'b0, '0});
        directed.push_back('{sws_pkg::FuncPush, Wmin, 1'b0, '0});
        directed.push_back('{sws_pkg::FuncPush, -64'sd1, 1'b0, '0});
        directed.push_back('{sws_pkg::FuncPush, 64'sd7, 1'b0, '0});
        directed.push_back('{sws_pkg::FuncRestart, 64'sd0, 1'b0, '0});
        directed.push_back('{sws_pkg::FuncPush, -64'sd3, 1'b0, '0});
        directed.push_back('{sws_pkg::FuncPush, 64'sd2, 1'b0, '0});
        foreach (directed[i]) begin
            if (directed[i].has_exp) begin
                got = predict_stats(directed[i].func, directed[i].sample);
                if (got !== directed[i].exp) begin
                    table_errors++;
                    $display("directed table row %0d disagrees", i);
                end
                expected_stats.push_back(directed[i].exp);
                offer_item(directed[i].func, directed[i].sample, 3);
            end else begin
                send_item(directed[i].func, directed[i].sample, 3);
            end
        end
        drain();

        // window 3: slide out extremes both ways, including ties
        write_window(7'd3);
        send_item(sws_pkg::FuncRestart, '0, 2);
        send_item(sws_pkg::FuncPush, 64'sd5, 2);
        send_item(sws_pkg::FuncPush, 64'sd1, 2);
        send_item(sws_pkg::FuncPush, 64'sd9, 2);
        send_item(sws_pkg::FuncPush, 64'sd5, 2);
        send_item(sws_pkg::FuncPush, 64'sd1, 2);
        send_item(sws_pkg::FuncPush, Wmin, 2);
        send_item(sws_pkg::FuncPush, Wmax, 2);
        send_item(sws_pkg::FuncPush, 64'sd0, 2);
        send_item(sws_pkg::FuncPush, 64'sd0, 2);
        drain();

        // random phases, restart first so history gets rewritten from head 0
        per_phase = RandomItems / 6;
        foreach (phases[p]) begin
            write_window(phases[p]);
            send_item(sws_pkg::FuncRestart, rand_sample(), 11);
            if (p == 3) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int unsigned n = 0; n < per_phase; n++) begin
                if ($urandom_range(0, 39) == 0)
                    send_item(sws_pkg::FuncRestart, rand_sample(), 11);
                else
                    send_item(sws_pkg::FuncPush, rand_sample(),
                              ($urandom_range(0, 4) == 0) ? 0 : 11);
            end
            drain();
        end

        if (mismatches == 0 && table_errors == 0 && expected_stats.size() == 0) begin
            $display("sliding_window_statistics_unit_tb: PASS");
        end else begin
            $display("sliding_window_statistics_unit_tb: FAIL");
        end
        $finish;
    end
endmodule
